>>> rtl/sscu_pkg.sv
// sscu_pkg: shared types, field widths and defaults for the sprite stripe clip unit
// no dependencies; used by every module in rtl/

package sscu_pkg;

   // field widths fixed by the transaction formats
   localparam int POS_W      = 12;
   localparam int ADDR_W     = 32;
   localparam int BAND_IDX_W = 4;
   localparam int SRC_OFF_W  = 10;
   localparam int DST_OFF_W  = 13;
   localparam int LEN_W      = 6;
   localparam int TIDX_W     = 8;

   // sprite geometry
   localparam int SPRITE_DIM   = 32;
   localparam int SPRITE_SHIFT = 5;

   // default screen and band geometry
   localparam int DEF_SCREEN_W   = 320;
   localparam int DEF_SCREEN_H   = 240;
   localparam int DEF_BAND_HEIGHT = 16;
   localparam int DEF_BAND_COUNT = 15;
   localparam int DEF_BAND_WIDTH = 320;

   // transparent index after reset
   localparam logic [TIDX_W-1:0] TRANSPARENT_RESET = 8'hFF;

   // queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // reciprocal divide by band height: operand width, shift, multiplier width
   localparam int DIV_ARG_W = 13;
   localparam int DIV_SHIFT = 19;
   localparam int RECIP_W   = 20;

   // descriptor slots of one sprite, in output order
   localparam int SLOT_COUNT = 3;
   typedef enum logic [1:0] {
      SLOT_FIRST = 2'd0,
      SLOT_MID   = 2'd1,
      SLOT_LAST  = 2'd2
   } slot_type;

   // input transaction
   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [ADDR_W-1:0]       src_base;
      logic [ADDR_W-1:0]       palette_base;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [BAND_IDX_W-1:0] stripe_index;
      logic [SRC_OFF_W-1:0]  src_offset;
      logic [DST_OFF_W-1:0]  dst_offset;
      logic [LEN_W-1:0]      draw_width;
      logic [LEN_W-1:0]      row_count;
      logic [ADDR_W-1:0]     src_addr;
      logic [ADDR_W-1:0]     palette_addr;
      logic [TIDX_W-1:0]     transparent_out;
      logic                  last;
   } rsp_type;

   // classified sprite handed from front end to back end
   typedef struct packed {
      logic [SLOT_COUNT-1:0] emit;
      logic [BAND_IDX_W-1:0] band0;
      logic [BAND_IDX_W-1:0] band1;
      logic [BAND_IDX_W-1:0] band2;
      logic [SRC_OFF_W-1:0]  src0;
      logic [SRC_OFF_W-1:0]  src1;
      logic [SRC_OFF_W-1:0]  src2;
      logic [DST_OFF_W-1:0]  dst0;
      logic [DST_OFF_W-1:0]  cx;
      logic [LEN_W-1:0]      width;
      logic [LEN_W-1:0]      rows0;
      logic [LEN_W-1:0]      rows2;
      logic [ADDR_W-1:0]     src_base;
      logic [ADDR_W-1:0]     palette_base;
   } entry_type;

endpackage

>>> rtl/sscu_front.sv
// sscu_front: three-stage classify pipeline (cull, x clip, band split) with queue credits
// depends on sscu_pkg; feeds sscu_queue

module sscu_front #(
   parameter int SCREEN_W    = sscu_pkg::DEF_SCREEN_W,
   parameter int SCREEN_H    = sscu_pkg::DEF_SCREEN_H,
   parameter int BAND_HEIGHT = sscu_pkg::DEF_BAND_HEIGHT,
   parameter int BAND_COUNT  = sscu_pkg::DEF_BAND_COUNT,
   parameter int BAND_WIDTH  = sscu_pkg::DEF_BAND_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  sscu_pkg::req_type     req_data,
   output logic                  q_push,
   output sscu_pkg::entry_type   q_entry,
   input  logic                  q_pop
);

   localparam int CRD_W  = sscu_pkg::POS_W + 1;
   localparam int A_W    = sscu_pkg::DIV_ARG_W;
   localparam int PROD_W = A_W + sscu_pkg::RECIP_W;
   localparam int QD_W   = A_W + sscu_pkg::LEN_W;
   localparam int BAND_W = A_W + 1;
   localparam int LEN_W  = sscu_pkg::LEN_W;
   localparam int SO_W   = sscu_pkg::SRC_OFF_W;
   localparam int DO_W   = sscu_pkg::DST_OFF_W;
   localparam int BI_W   = sscu_pkg::BAND_IDX_W;
   localparam int CX_W   = sscu_pkg::POS_W - 1;
   localparam int ADDR_W = sscu_pkg::ADDR_W;
   localparam int SH     = sscu_pkg::SPRITE_SHIFT;
   localparam int CNT_W  = $clog2(sscu_pkg::QUEUE_DEPTH + 1);

   // floor division made non-negative by a bias of whole bands
   localparam int OFF_Q = ((1 << (sscu_pkg::POS_W - 1)) + BAND_HEIGHT - 1) / BAND_HEIGHT;
   localparam int OFF_A = OFF_Q * BAND_HEIGHT;
   localparam int RECIP = (1 << sscu_pkg::DIV_SHIFT) / BAND_HEIGHT + 1;

   localparam logic signed [CRD_W-1:0]  LOW_LIM = CRD_W'(-sscu_pkg::SPRITE_DIM);
   localparam logic signed [CRD_W-1:0]  SCR_W_S = CRD_W'(SCREEN_W);
   localparam logic signed [CRD_W-1:0]  SCR_H_S = CRD_W'(SCREEN_H);
   localparam logic signed [BAND_W-1:0] ZERO_B  = '0;
   localparam logic signed [BAND_W-1:0] ONE_B   = BAND_W'(1);
   localparam logic signed [BAND_W-1:0] BCNT_S  = BAND_W'(BAND_COUNT);
   localparam logic [BAND_W-1:0]        OFF_Q_B = BAND_W'(OFF_Q);
   localparam logic [SO_W-1:0]          MID_SRC = SO_W'(BAND_HEIGHT * sscu_pkg::SPRITE_DIM);

   typedef struct packed {
      logic              keep;
      logic [A_W-1:0]    a1;
      logic [PROD_W-1:0] p1;
      logic [PROD_W-1:0] p2;
      logic [CX_W-1:0]   cx;
      logic [LEN_W-1:0]  left;
      logic [LEN_W-1:0]  width;
      logic [ADDR_W-1:0] sb;
      logic [ADDR_W-1:0] pb;
   } s1_type;

   typedef struct packed {
      logic              keep;
      logic [A_W-1:0]    a1;
      logic [A_W-1:0]    q1;
      logic [A_W-1:0]    q2;
      logic [QD_W-1:0]   qd1;
      logic [QD_W-1:0]   qd2;
      logic [CX_W-1:0]   cx;
      logic [LEN_W-1:0]  left;
      logic [LEN_W-1:0]  width;
      logic [ADDR_W-1:0] sb;
      logic [ADDR_W-1:0] pb;
   } s2_type;

   logic                accept;
   logic                drop;
   logic [CNT_W-1:0]    credit_ff, credit_in;
   logic                v1_ff, v2_ff, v3_ff;
   logic                keep3_ff, keep3_in;
   s1_type              s1_ff, s1_in;
   s2_type              s2_ff, s2_in;
   sscu_pkg::entry_type e3_ff, e3_in;

   logic signed [CRD_W-1:0]  px, py, xend;
   logic [LEN_W-1:0]         wfull;
   logic [A_W-1:0]           a2;
   logic [LEN_W-1:0]         rowoff, rowoff2, rows0;
   logic signed [BAND_W-1:0] first, mid, last;
   logic                     has_mid;
   logic [SO_W-1:0]          src0, src1;

   assign accept = req_push && !req_full;
   assign req_full = (credit_ff == CNT_W'(sscu_pkg::QUEUE_DEPTH));

   // stage 1: cull test, x clip, reciprocal products for the band split
   always_comb begin
      px = {req_data.pos_x[sscu_pkg::POS_W-1], req_data.pos_x};
      py = {req_data.pos_y[sscu_pkg::POS_W-1], req_data.pos_y};
      s1_in.keep = (px > LOW_LIM) && (px < SCR_W_S) && (py > LOW_LIM) && (py < SCR_H_S);
      s1_in.a1 = A_W'(py) + A_W'(OFF_A);
      s1_in.p1 = PROD_W'(s1_in.a1) * PROD_W'(RECIP);
      s1_in.p2 = PROD_W'(s1_in.a1 + A_W'(sscu_pkg::SPRITE_DIM - 1)) * PROD_W'(RECIP);
      s1_in.left = px[CRD_W-1] ? LEN_W'(-px) : '0;
      s1_in.cx = px[CRD_W-1] ? '0 : px[CX_W-1:0];
      wfull = LEN_W'(sscu_pkg::SPRITE_DIM) - s1_in.left;
      xend = px + $signed({{(CRD_W-LEN_W){1'b0}}, wfull});
      s1_in.width = (xend > SCR_W_S) ? LEN_W'(SCR_W_S - px) : wfull;
      s1_in.sb = req_data.src_base;
      s1_in.pb = req_data.palette_base;
   end

   // stage 2: band quotients and their band start rows
   always_comb begin
      s2_in.keep = s1_ff.keep;
      s2_in.a1 = s1_ff.a1;
      s2_in.q1 = s1_ff.p1[sscu_pkg::DIV_SHIFT +: A_W];
      s2_in.q2 = s1_ff.p2[sscu_pkg::DIV_SHIFT +: A_W];
      s2_in.qd1 = QD_W'(s2_in.q1) * QD_W'(BAND_HEIGHT);
      s2_in.qd2 = QD_W'(s2_in.q2) * QD_W'(BAND_HEIGHT);
      s2_in.cx = s1_ff.cx;
      s2_in.left = s1_ff.left;
      s2_in.width = s1_ff.width;
      s2_in.sb = s1_ff.sb;
      s2_in.pb = s1_ff.pb;
   end

   // stage 3: row offsets, band range checks, source offsets, first dst offset
   always_comb begin
      a2 = s2_ff.a1 + A_W'(sscu_pkg::SPRITE_DIM - 1);
      rowoff = LEN_W'(QD_W'(s2_ff.a1) - s2_ff.qd1);
      rowoff2 = LEN_W'(QD_W'(a2) - s2_ff.qd2);
      first = $signed({1'b0, s2_ff.q1}) - $signed(OFF_Q_B);
      last = $signed({1'b0, s2_ff.q2}) - $signed(OFF_Q_B);
      mid = first + ONE_B;
      has_mid = last > mid;
      rows0 = LEN_W'(BAND_HEIGHT) - rowoff;
      src0 = SO_W'(s2_ff.left);
      src1 = src0 + SO_W'({rows0, {SH{1'b0}}});

      keep3_in = s2_ff.keep;
      e3_in.emit[sscu_pkg::SLOT_FIRST] = (first >= ZERO_B) && (first < BCNT_S);
      e3_in.emit[sscu_pkg::SLOT_MID] = has_mid && (mid >= ZERO_B) && (mid < BCNT_S);
      e3_in.emit[sscu_pkg::SLOT_LAST] = (last > first) && (last >= ZERO_B) && (last < BCNT_S);
      e3_in.band0 = first[BI_W-1:0];
      e3_in.band1 = mid[BI_W-1:0];
      e3_in.band2 = last[BI_W-1:0];
      e3_in.src0 = src0;
      e3_in.src1 = src1;
      e3_in.src2 = src1 + (has_mid ? MID_SRC : '0);
      e3_in.dst0 = DO_W'(rowoff) * DO_W'(BAND_WIDTH);
      e3_in.cx = DO_W'(s2_ff.cx);
      e3_in.width = s2_ff.width;
      e3_in.rows0 = rows0;
      e3_in.rows2 = rowoff2 + LEN_W'(1);
      e3_in.src_base = s2_ff.sb;
      e3_in.palette_base = s2_ff.pb;
   end

   // hand over sprites with something to draw, drop the rest
   assign q_push = v3_ff && keep3_ff && (e3_ff.emit != '0);
   assign drop = v3_ff && !q_push;
   assign q_entry = e3_ff;

   // one credit per sprite in the pipeline or the queue
   assign credit_in = credit_ff + CNT_W'(accept) - CNT_W'(q_pop) - CNT_W'(drop);

   // pipeline valids and credit count
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         credit_ff <= '0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         credit_ff <= credit_in;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      e3_ff <= e3_in;
      keep3_ff <= keep3_in;
   end

endmodule

>>> rtl/sscu_queue.sv
// sscu_queue: small register queue of classified sprites between front and back end
// depends on sscu_pkg

module sscu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sscu_pkg::entry_type push_entry,
   input  logic                pop,
   output sscu_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   localparam int DEPTH = sscu_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sscu_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CNT_W'(DEPTH));
   assign head = mem_ff[rd_ptr_ff];

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/sscu_back.sv
// sscu_back: walks the head sprite's slots, one per cycle unless stalled, into the result register
// depends on sscu_pkg; reads the head of sscu_queue

module sscu_back #(
   parameter int BAND_HEIGHT = sscu_pkg::DEF_BAND_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sscu_pkg::entry_type           head,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [sscu_pkg::TIDX_W-1:0]   transparent,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output sscu_pkg::rsp_type             rsp_data
);

   localparam int NS    = sscu_pkg::SLOT_COUNT;
   localparam int LEN_W = sscu_pkg::LEN_W;

   sscu_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NS-1:0]      done_ff, done_in;
   logic [NS-1:0]      rem;
   logic [NS-1:0]      sel_mask;
   sscu_pkg::slot_type slot;
   logic               load;
   logic               is_last;

   // lowest slot of the head sprite not yet sent
   always_comb begin
      rem = head.emit & ~done_ff;
      if (rem[sscu_pkg::SLOT_FIRST]) begin
         slot = sscu_pkg::SLOT_FIRST;
      end else if (rem[sscu_pkg::SLOT_MID]) begin
         slot = sscu_pkg::SLOT_MID;
      end else begin
         slot = sscu_pkg::SLOT_LAST;
      end
      sel_mask = '0;
      sel_mask[slot] = 1'b1;
      is_last = ((rem & ~sel_mask) == '0);
   end

   assign load = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop = load && is_last;

   // descriptor for the chosen slot
   always_comb begin
      rsp_in.src_addr = head.src_base;
      rsp_in.palette_addr = head.palette_base;
      rsp_in.transparent_out = transparent;
      rsp_in.draw_width = head.width;
      rsp_in.last = is_last;
      rsp_in.dst_offset = head.cx;
      case (slot)
         sscu_pkg::SLOT_FIRST: begin
            rsp_in.stripe_index = head.band0;
            rsp_in.src_offset = head.src0;
            rsp_in.dst_offset = head.dst0 + head.cx;
            rsp_in.row_count = head.rows0;
         end
         sscu_pkg::SLOT_MID: begin
            rsp_in.stripe_index = head.band1;
            rsp_in.src_offset = head.src1;
            rsp_in.row_count = LEN_W'(BAND_HEIGHT);
         end
         sscu_pkg::SLOT_LAST: begin
            rsp_in.stripe_index = head.band2;
            rsp_in.src_offset = head.src2;
            rsp_in.row_count = head.rows2;
         end
         default: begin
            rsp_in.stripe_index = '0;
            rsp_in.src_offset = '0;
            rsp_in.row_count = '0;
         end
      endcase
   end

   // slot progress and result register valid
   always_comb begin
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (load) begin
         done_in = is_last ? '0 : (done_ff | sel_mask);
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> rtl/sprite_stripe_clip_unit.sv
// sprite_stripe_clip_unit: top level tying front end, queue, back end and the transparent register
// depends on sscu_pkg, sscu_front, sscu_queue, sscu_back

// Takes one 32x32 sprite per transaction and returns zero to three stripe blit descriptors
// (first band, next band, last band) in that order, the final one flagged with last. At most
// four sprites sit in the front end and the four-entry queue together. A sprite's credit
// comes back when its last descriptor is loaded for output, or when it is dropped with
// nothing to draw. So with the result side ready, new sprites are taken while earlier
// ones are still in flight, until all four credits are in use. A three-stage front end
// culls each sprite, clips it in x and splits it into bands, and the queue hands it to the
// back end. The back end sends one descriptor per cycle while the result side is ready,
// so a sprite holds it until all of its descriptors (at most three) are loaded, and culled
// or fully out-of-range sprites cost it none. The transparent index is read when each
// descriptor is formed and should be written only while the unit is idle.

module sprite_stripe_clip_unit #(
   parameter int SCREEN_W    = sscu_pkg::DEF_SCREEN_W,
   parameter int SCREEN_H    = sscu_pkg::DEF_SCREEN_H,
   parameter int BAND_HEIGHT = sscu_pkg::DEF_BAND_HEIGHT,
   parameter int BAND_COUNT  = sscu_pkg::DEF_BAND_COUNT,
   parameter int BAND_WIDTH  = sscu_pkg::DEF_BAND_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  sscu_pkg::req_type           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output sscu_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [sscu_pkg::TIDX_W-1:0] csr_wr_data
);

   logic [sscu_pkg::TIDX_W-1:0] transparent_ff, transparent_in;
   logic                        q_push;
   logic                        q_pop;
   logic                        q_empty;
   logic                        q_full;
   sscu_pkg::entry_type         q_entry;
   sscu_pkg::entry_type         q_head;

   // transparent index register
   assign transparent_in = csr_wr_en ? csr_wr_data : transparent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_ff <= sscu_pkg::TRANSPARENT_RESET;
      end else begin
         transparent_ff <= transparent_in;
      end
   end

   // classify pipeline
   sscu_front #(
      .SCREEN_W    (SCREEN_W),
      .SCREEN_H    (SCREEN_H),
      .BAND_HEIGHT (BAND_HEIGHT),
      .BAND_COUNT  (BAND_COUNT),
      .BAND_WIDTH  (BAND_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   // decoupling queue
   sscu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // descriptor emitter
   sscu_back #(
      .BAND_HEIGHT (BAND_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .transparent (transparent_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

`ifndef ASSERT_OFF
   // credits must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full && !q_pop))
      else $error("queue push while full");

   // every queued sprite has at least one descriptor to send
   a_head_emits: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (q_head.emit != '0))
      else $error("queued sprite with no descriptor");

   // a sprite's descriptors follow each other without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=> !rsp_empty)
      else $error("gap inside a sprite's descriptors");

   // the back end never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");
`endif

endmodule

>>> test/sscu_checker.sv
// sscu_checker: watches the sprite, descriptor and register ports of the stripe clip unit,
// predicts every descriptor and compares it with what the unit returns
// depends on sscu_pkg

module sscu_checker #(
   parameter int SCREEN_W    = sscu_pkg::DEF_SCREEN_W,
   parameter int SCREEN_H    = sscu_pkg::DEF_SCREEN_H,
   parameter int BAND_HEIGHT = sscu_pkg::DEF_BAND_HEIGHT,
   parameter int BAND_COUNT  = sscu_pkg::DEF_BAND_COUNT,
   parameter int BAND_WIDTH  = sscu_pkg::DEF_BAND_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic                        req_full,
   input  sscu_pkg::req_type           req_data,
   input  logic                        rsp_empty,
   input  logic                        rsp_pop,
   input  sscu_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [sscu_pkg::TIDX_W-1:0] csr_wr_data,
   output int                          fail_count,
   output int                          pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam int SPR          = sscu_pkg::SPRITE_DIM;

   logic [sscu_pkg::TIDX_W-1:0] transparent_copy = sscu_pkg::TRANSPARENT_RESET;
   sscu_pkg::rsp_type           descriptor_queue[$];
   int                          mismatches = 0;

   // quotient rounded toward minus infinity
   function automatic int floor_quot(input int num, input int den);
      int q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic sscu_pkg::rsp_type form_descriptor(input int band, input int src,
                                                         input int dst, input int width,
                                                         input int rows,
                                                         input sscu_pkg::req_type item,
                                                         input logic [7:0] tidx);
      sscu_pkg::rsp_type d;
      d.stripe_index    = sscu_pkg::BAND_IDX_W'(band);
      d.src_offset      = sscu_pkg::SRC_OFF_W'(src);
      d.dst_offset      = sscu_pkg::DST_OFF_W'(dst);
      d.draw_width      = sscu_pkg::LEN_W'(width);
      d.row_count       = sscu_pkg::LEN_W'(rows);
      d.src_addr        = item.src_base;
      d.palette_addr    = item.palette_base;
      d.transparent_out = tidx;
      d.last            = 1'b0;
      return d;
   endfunction

   // cull, clip in x, split into bands and queue the descriptors in output order
   function automatic void predict_descriptors(input sscu_pkg::req_type item,
                                               input logic [7:0] tidx);
      int                px;
      int                py;
      int                first_band;
      int                last_band;
      int                row_off;
      int                rows;
      int                cx;
      int                left;
      int                width;
      int                src_pos;
      int                count;
      sscu_pkg::rsp_type slots[sscu_pkg::SLOT_COUNT];
      px = $signed(item.pos_x);
      py = $signed(item.pos_y);
      count = 0;
      if (!(px > -SPR && px < SCREEN_W && py > -SPR && py < SCREEN_H))
         return;
      first_band = floor_quot(py, BAND_HEIGHT);
      last_band  = floor_quot(py + SPR - 1, BAND_HEIGHT);
      row_off    = py - first_band * BAND_HEIGHT;
      left       = (px >= 0) ? 0 : -px;
      cx         = (px >= 0) ? px : 0;
      width      = SPR - left;
      if (px + width > SCREEN_W) width = SCREEN_W - px;
      src_pos = left;
      // first band, its source rows count even when the band is above the screen
      rows = BAND_HEIGHT - row_off;
      if (first_band >= 0 && first_band < BAND_COUNT) begin
         slots[count] = form_descriptor(first_band, src_pos, row_off * BAND_WIDTH + cx,
                                        width, rows, item, tidx);
         count++;
      end
      src_pos += rows * SPR;
      // one full middle band at most
      if (last_band > first_band + 1) begin
         if (first_band + 1 >= 0 && first_band + 1 < BAND_COUNT) begin
            slots[count] = form_descriptor(first_band + 1, src_pos, cx, width,
                                           BAND_HEIGHT, item, tidx);
            count++;
         end
         src_pos += BAND_HEIGHT * SPR;
      end
      // last band
      rows = py + SPR - last_band * BAND_HEIGHT;
      if (last_band > first_band && last_band >= 0 && last_band < BAND_COUNT) begin
         slots[count] = form_descriptor(last_band, src_pos, cx, width, rows, item, tidx);
         count++;
      end
      for (int i = 0; i < count; i++) begin
         if (i == count - 1) slots[i].last = 1'b1;
         descriptor_queue.push_back(slots[i]);
      end
   endfunction

   function automatic string describe(input sscu_pkg::rsp_type d);
      return $sformatf({"band %0d src %0d dst %0d width %0d rows %0d",
                        " saddr %h paddr %h tidx %h last %0b"},
                       d.stripe_index, d.src_offset, d.dst_offset, d.draw_width, d.row_count,
                       d.src_addr, d.palette_addr, d.transparent_out, d.last);
   endfunction

   // register writes, result transactions, then sprite transactions
   always @(posedge clock) begin : monitor
      sscu_pkg::rsp_type want;
      string             wrong;
      if (reset) begin
         transparent_copy = sscu_pkg::TRANSPARENT_RESET;
         descriptor_queue.delete();
      end else begin
         if (csr_wr_en) transparent_copy = csr_wr_data;
         if (rsp_pop && !rsp_empty) begin
            if (descriptor_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected descriptor: %s", describe(rsp_data));
            end else begin
               want  = descriptor_queue.pop_front();
               wrong = "";
               if (rsp_data.stripe_index !== want.stripe_index) wrong = {wrong, " stripe_index"};
               if (rsp_data.src_offset !== want.src_offset) wrong = {wrong, " src_offset"};
               if (rsp_data.dst_offset !== want.dst_offset) wrong = {wrong, " dst_offset"};
               if (rsp_data.draw_width !== want.draw_width) wrong = {wrong, " draw_width"};
               if (rsp_data.row_count !== want.row_count) wrong = {wrong, " row_count"};
               if (rsp_data.src_addr !== want.src_addr) wrong = {wrong, " src_addr"};
               if (rsp_data.palette_addr !== want.palette_addr) wrong = {wrong, " palette_addr"};
               if (rsp_data.transparent_out !== want.transparent_out)
                  wrong = {wrong, " transparent_out"};
               if (rsp_data.last !== want.last) wrong = {wrong, " last"};
               if (wrong != "") begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("descriptor mismatch in%s", wrong);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_data));
                  end
               end
            end
         end
         if (req_push && !req_full) predict_descriptors(req_data, transparent_copy);
      end
      fail_count <= mismatches;
      pending    <= descriptor_queue.size();
   end

endmodule

>>> test/tb_top.sv
// tb_top: stimulus, idling and verdict for the sprite stripe clip unit
// depends on sscu_pkg, sprite_stripe_clip_unit and sscu_checker

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POS_W          = sscu_pkg::POS_W;
   localparam int TIDX_W         = sscu_pkg::TIDX_W;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_push    = 1'b0;
   logic                        req_full;
   sscu_pkg::req_type           req_data    = '0;
   logic                        rsp_empty;
   logic                        rsp_pop     = 1'b0;
   sscu_pkg::rsp_type           rsp_data;
   logic                        csr_wr_en   = 1'b0;
   logic [sscu_pkg::TIDX_W-1:0] csr_wr_data = '0;
   int                          fail_count;
   int                          pending;
   int                          idle_cycles = 0;
   bit                          burst_mode  = 1'b0;

   sprite_stripe_clip_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sscu_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic sscu_pkg::req_type make_sprite(input int px, input int py,
                                                     input logic [31:0] sbase,
                                                     input logic [31:0] pbase);
      sscu_pkg::req_type item;
      item.pos_x        = POS_W'(px);
      item.pos_y        = POS_W'(py);
      item.src_base     = sbase;
      item.palette_base = pbase;
      return item;
   endfunction

   // mostly sprites near the screen, the rest anywhere in the coordinate range
   function automatic sscu_pkg::req_type random_sprite();
      sscu_pkg::req_type item;
      if ($urandom_range(0, 9) == 0) begin
         item.pos_x = POS_W'($urandom);
         item.pos_y = POS_W'($urandom);
      end else begin
         item.pos_x = POS_W'(int'($urandom_range(0, 370)) - 40);
         item.pos_y = POS_W'(int'($urandom_range(0, 290)) - 40);
      end
      item.src_base     = $urandom;
      item.palette_base = $urandom;
      return item;
   endfunction

   // present one sprite and hold it until the unit takes it
   task automatic send_sprite(input sscu_pkg::req_type item);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
   endtask

   // stop sending until every descriptor is back and culled sprites have drained
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_transparent(input logic [sscu_pkg::TIDX_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_sprite(random_sprite());
   endtask

   // descriptor side: alternating stretches of pops and stalls
   initial begin : pop_driver
      int stretch;
      bit popping;
      stretch = 0;
      popping = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            popping = !popping;
            stretch = popping ? $urandom_range(1, 24) : pick_gap();
         end
         if (stretch > 0) stretch--;
         rsp_pop <= popping || burst_mode;
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sprites at the reset transparent index
      send_sprite(make_sprite(0, 0, 32'h0000_0000, 32'h0000_0000));
      send_sprite(make_sprite(-32, 0, 32'h1111_1111, 32'h2222_2222));
      send_sprite(make_sprite(-31, 10, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_sprite(make_sprite(319, 100, 32'hAAAA_AAAA, 32'h5555_5555));
      send_sprite(make_sprite(320, 100, 32'h5555_5555, 32'hAAAA_AAAA));
      send_sprite(make_sprite(2047, 2047, 32'h1234_5678, 32'h9ABC_DEF0));
      send_sprite(make_sprite(-2048, -2048, 32'hFFFF_0000, 32'h0000_FFFF));
      send_sprite(make_sprite(100, -32, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
      // rows above the screen that still move the source offset
      send_sprite(make_sprite(100, -31, 32'hAAAA_AAAA, 32'h5555_5555));
      send_sprite(make_sprite(100, -17, 32'h5555_5555, 32'hAAAA_AAAA));
      send_sprite(make_sprite(100, -1, 32'hDEAD_BEEF, 32'hCAFE_F00D));
      // three bands, two aligned bands, bottom bands past the last stripe
      send_sprite(make_sprite(50, 8, 32'h0000_0001, 32'h8000_0000));
      send_sprite(make_sprite(50, 16, 32'h8000_0000, 32'h0000_0001));
      send_sprite(make_sprite(50, 208, 32'h1357_9BDF, 32'h2468_ACE0));
      send_sprite(make_sprite(50, 224, 32'hFFFF_FFFF, 32'h0000_0000));
      send_sprite(make_sprite(50, 239, 32'h0000_0000, 32'hFFFF_FFFF));
      send_sprite(make_sprite(100, 240, 32'h7777_7777, 32'h8888_8888));
      // left and right clipping
      send_sprite(make_sprite(300, 40, 32'hAAAA_5555, 32'h5555_AAAA));
      send_sprite(make_sprite(-10, 40, 32'h0123_4567, 32'h89AB_CDEF));
      send_sprite(make_sprite(288, 50, 32'hFEDC_BA98, 32'h7654_3210));
      send_sprite(make_sprite(289, 50, 32'h3333_3333, 32'hCCCC_CCCC));
      send_sprite(make_sprite(-1, 239, 32'hC3C3_C3C3, 32'h3C3C_3C3C));
      send_sprite(make_sprite(0, 2047, 32'h0000_0000, 32'h0000_0000));

      // random sprites over several transparent settings
      write_transparent(8'h00);
      send_random(50);

      write_transparent(8'h80);
      burst_mode = 1'b1;
      send_random(50);
      burst_mode = 1'b0;

      write_transparent(TIDX_W'($urandom));
      send_random(50);

      write_transparent(8'h01);
      send_random(20);
      wait_drained();
      send_random(20);

      wait_drained();
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sprite_stripe_clip_unit.f
rtl/sscu_pkg.sv
rtl/sscu_front.sv
rtl/sscu_queue.sv
rtl/sscu_back.sv
rtl/sprite_stripe_clip_unit.sv
test/sscu_checker.sv
test/tb_top.sv
